FILE: rtl/memory_map_normalizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the memory map normalizer
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef MEMORY_MAP_NORMALIZER_ASSERT_SVH
`define MEMORY_MAP_NORMALIZER_ASSERT_SVH

// Check that a implies b in the same cycle
`define MMN_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// Check that a implies b in the following cycle
`define MMN_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/mmn_pkg.sv
// ----------------------------------------------------------------------------
// Memory map normalizer package
// Shared types, constants and register indexes.
// ----------------------------------------------------------------------------
package mmn_pkg;

   localparam int MAX_ENTRIES_DEF = 32;
   localparam int ADDR_W          = 64;
   localparam int FIELD_W         = 32;
   localparam int PAGE_BITS       = 12;
   localparam int CSR_IDX_W       = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AVAIL_TYPE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQ_FLAGS  = 1'd1;

   localparam logic [FIELD_W-1:0] AVAIL_TYPE_RST = 32'd1;
   localparam logic [FIELD_W-1:0] REQ_FLAGS_RST  = 32'd1;

   // One stored interval [base, end)
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] limit;
   } cell_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_mode_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MERGE,
      ST_ROUND,
      ST_SIZE,
      ST_FINISH
   } mmn_state_type;

   // Result item as held in the output register
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] size;
      logic              valid;
      logic              last;
   } region_type;

endpackage

FILE: rtl/memory_map_normalizer.sv
// ----------------------------------------------------------------------------
// Memory map normalizer
// Collects firmware memory map entries and emits sorted, merged, page-aligned
// free regions.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one map entry per item. Entries whose type and extension flags
//            match the csr registers and whose size is nonzero are kept in a
//            sorted chain of MAX_ENTRIES cells; later ones are ignored.
//   rsp_*  : free regions in ascending order, last_region on the final one;
//            an empty map gives one item with region_valid low.
//   csr_*  : index 0 available type, index 1 required flags; always ready.
// Timing: loading takes one entry per cycle while req_stall is low. After the
//   entry with last_entry, req_stall stays high while the chain drains into
//   the merge unit and its regions are emitted, also while the output
//   register waits on rsp_stall.
// Reset clears the entry count and sets the csr registers to 1; the cells need no clear.
// A stalled rsp holds its item; the merge unit waits on a full output
// register and resumes when it is taken.
// ----------------------------------------------------------------------------
`include "memory_map_normalizer_assert.svh"

module memory_map_normalizer #(
   parameter int MAX_ENTRIES = mmn_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mmn_pkg::ADDR_W-1:0]        req_entry_base,
   input  logic [mmn_pkg::ADDR_W-1:0]        req_entry_size,
   input  logic [mmn_pkg::FIELD_W-1:0]       req_entry_type,
   input  logic [mmn_pkg::FIELD_W-1:0]       req_entry_ext,
   input  logic                              req_last_entry,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mmn_pkg::ADDR_W-1:0]        rsp_region_base,
   output logic [mmn_pkg::ADDR_W-1:0]        rsp_region_size,
   output logic                              rsp_region_valid,
   output logic                              rsp_last_region,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mmn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmn_pkg::FIELD_W-1:0]       csr_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [mmn_pkg::FIELD_W-1:0] avail_ff, avail_in;
   logic [mmn_pkg::FIELD_W-1:0] flags_ff, flags_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        accept;
   logic                        keep;
   logic [mmn_pkg::ADDR_W:0]    end_sum;
   mmn_pkg::cell_type           new_item;
   mmn_pkg::cell_mode_type      mode;
   mmn_pkg::cell_type           cell_q [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0]      go;
   logic                        busy;
   logic                        shift;
   logic [CNT_W-1:0]            start_count;
   mmn_pkg::region_type         rsp_item;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   // Configuration writes
   always_comb begin
      avail_in = avail_ff;
      flags_in = flags_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mmn_pkg::CSR_AVAIL_TYPE: avail_in = csr_data;
            mmn_pkg::CSR_REQ_FLAGS:  flags_in = csr_data;
            default: begin
               avail_in = avail_ff;
            end
         endcase
      end
   end

   // Filter the entry and saturate its end
   assign end_sum = {1'b0, req_entry_base} + {1'b0, req_entry_size};
   assign new_item.base  = req_entry_base;
   assign new_item.limit = end_sum[mmn_pkg::ADDR_W] ? {mmn_pkg::ADDR_W{1'b1}} :
                           end_sum[mmn_pkg::ADDR_W-1:0];
   assign keep = (req_entry_type == avail_ff) && (req_entry_ext == flags_ff) &&
                 (req_entry_size != '0) && (count_ff < CNT_W'(MAX_ENTRIES));

   assign start_count = keep ? count_ff + CNT_W'(1) : count_ff;

   // Count stored entries, clear on the last entry
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req_last_entry ? '0 : start_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= mmn_pkg::AVAIL_TYPE_RST;
         flags_ff <= mmn_pkg::REQ_FLAGS_RST;
         count_ff <= '0;
      end else begin
         avail_ff <= avail_in;
         flags_ff <= flags_in;
         count_ff <= count_in;
      end
   end

   // Chain operation
   always_comb begin
      if (shift) begin
         mode = mmn_pkg::CELL_SHIFT;
      end else if (accept && keep) begin
         mode = mmn_pkg::CELL_INSERT;
      end else begin
         mode = mmn_pkg::CELL_HOLD;
      end
   end

   // Sorted chain of interval cells, head at index 0
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      mmn_pkg::cell_type prev_q;
      mmn_pkg::cell_type next_q;
      logic              prev_go;

      if (i == 0) begin : g_head
         assign prev_q  = new_item;
         assign prev_go = 1'b0;
      end else begin : g_body
         assign prev_q  = cell_q[i-1];
         assign prev_go = go[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_q = cell_q[i];
      end else begin : g_mid
         assign next_q = cell_q[i+1];
      end

      mmn_cell u_cell (
         .clock    (clock),
         .mode     (mode),
         .occupied (count_ff > CNT_W'(i)),
         .new_item (new_item),
         .prev_q   (prev_q),
         .prev_go  (prev_go),
         .next_q   (next_q),
         .cell_q   (cell_q[i]),
         .go       (go[i])
      );
   end

   mmn_merge #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .start       (accept && req_last_entry),
      .start_count (start_count),
      .head        (cell_q[0]),
      .busy        (busy),
      .shift       (shift),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   assign rsp_region_base  = rsp_item.base;
   assign rsp_region_size  = rsp_item.size;
   assign rsp_region_valid = rsp_item.valid;
   assign rsp_last_region  = rsp_item.last;

   // Final entry starts the merge pass
   `MMN_ASSERT_NEXT(a_last_starts_merge, clock, reset,
      accept && req_last_entry, req_stall)
   // Given regions are page aligned and nonempty
   `MMN_ASSERT_NOW(a_region_aligned, clock, reset, rsp_valid && rsp_region_valid,
      rsp_region_base[11:0] == 12'd0 && rsp_region_size[11:0] == 12'd0 &&
      rsp_region_size != '0)
   // An empty map result closes the run
   `MMN_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid && !rsp_region_valid,
      rsp_last_region && rsp_region_size == '0)
   // Entry count stays within the chain
   `MMN_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(MAX_ENTRIES))

endmodule

FILE: rtl/mmn_cell.sv
// ----------------------------------------------------------------------------
// Sort cell
// Holds one interval of the sorted chain; inserts, holds or shifts toward head.
// ----------------------------------------------------------------------------
module mmn_cell (
   input  logic                   clock,
   input  mmn_pkg::cell_mode_type mode,
   input  logic                   occupied,
   input  mmn_pkg::cell_type      new_item,
   input  mmn_pkg::cell_type      prev_q,
   input  logic                   prev_go,
   input  mmn_pkg::cell_type      next_q,
   output mmn_pkg::cell_type      cell_q,
   output logic                   go
);

   mmn_pkg::cell_type cell_ff;
   mmn_pkg::cell_type cell_in;

   // New item belongs here or before here
   assign go = !occupied || (cell_ff.base > new_item.base);

   always_comb begin
      cell_in = cell_ff;
      case (mode)
         mmn_pkg::CELL_HOLD: begin
            cell_in = cell_ff;
         end
         mmn_pkg::CELL_INSERT: begin
            if (go) begin
               cell_in = prev_go ? prev_q : new_item;
            end
         end
         mmn_pkg::CELL_SHIFT: begin
            cell_in = next_q;
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_q = cell_ff;

endmodule

FILE: rtl/mmn_merge.sv
// ----------------------------------------------------------------------------
// Merge and page-round unit
// Drains the sorted chain, merges intervals, rounds to pages and emits items.
// ----------------------------------------------------------------------------
module mmn_merge #(
   parameter int MAX_ENTRIES = mmn_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]     start_count,
   input  mmn_pkg::cell_type                    head,
   output logic                                 busy,
   output logic                                 shift,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output mmn_pkg::region_type                  rsp_item
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int AW    = mmn_pkg::ADDR_W;
   localparam int PB    = mmn_pkg::PAGE_BITS;

   mmn_pkg::mmn_state_type state_ff, state_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic                have_ff, have_in;
   logic [AW-1:0]       cs_ff, cs_in, ce_ff, ce_in;
   logic [AW-1:0]       cand_s_ff, cand_s_in, cand_e_ff, cand_e_in;
   logic                final_ff, final_in;
   logic [AW-1:0]       rl_ff, rl_in, rh_ff, rh_in;
   logic                rok_ff, rok_in;
   logic                pend_v_ff, pend_v_in;
   logic [AW-1:0]       pend_b_ff, pend_b_in, pend_s_ff, pend_s_in;
   logic                out_v_ff, out_v_in;
   mmn_pkg::region_type out_ff, out_in;

   logic                out_free;
   logic                start_ok;
   logic [AW-1:0]       lo_val;
   logic [AW-1:0]       hi_val;

   assign out_free = !out_v_ff || !rsp_stall;

   // Round start up and end down to a page
   assign start_ok = (cand_s_ff[AW-1:PB] != {(AW-PB){1'b1}}) ||
                     (cand_s_ff[PB-1:0] == '0);
   assign lo_val   = (cand_s_ff[PB-1:0] != '0) ?
                     {cand_s_ff[AW-1:PB] + (AW-PB)'(1), {PB{1'b0}}} : cand_s_ff;
   assign hi_val   = {cand_e_ff[AW-1:PB], {PB{1'b0}}};

   // Next state and datapath
   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      have_in   = have_ff;
      cs_in     = cs_ff;
      ce_in     = ce_ff;
      cand_s_in = cand_s_ff;
      cand_e_in = cand_e_ff;
      final_in  = final_ff;
      rl_in     = rl_ff;
      rh_in     = rh_ff;
      rok_in    = rok_ff;
      pend_v_in = pend_v_ff;
      pend_b_in = pend_b_ff;
      pend_s_in = pend_s_ff;
      out_v_in  = out_v_ff && rsp_stall;
      out_in    = out_ff;
      shift     = 1'b0;
      case (state_ff)
         mmn_pkg::ST_LOAD: begin
            if (start) begin
               state_in  = mmn_pkg::ST_MERGE;
               remain_in = start_count;
               have_in   = 1'b0;
               pend_v_in = 1'b0;
            end
         end
         mmn_pkg::ST_MERGE: begin
            if (remain_ff != '0) begin
               shift     = 1'b1;
               remain_in = remain_ff - CNT_W'(1);
               if (!have_ff) begin
                  have_in = 1'b1;
                  cs_in   = head.base;
                  ce_in   = head.limit;
               end else if (head.base <= ce_ff) begin
                  if (head.limit > ce_ff) begin
                     ce_in = head.limit;
                  end
               end else begin
                  cand_s_in = cs_ff;
                  cand_e_in = ce_ff;
                  final_in  = 1'b0;
                  cs_in     = head.base;
                  ce_in     = head.limit;
                  state_in  = mmn_pkg::ST_ROUND;
               end
            end else if (have_ff) begin
               cand_s_in = cs_ff;
               cand_e_in = ce_ff;
               final_in  = 1'b1;
               have_in   = 1'b0;
               state_in  = mmn_pkg::ST_ROUND;
            end else begin
               state_in = mmn_pkg::ST_FINISH;
            end
         end
         mmn_pkg::ST_ROUND: begin
            rl_in    = lo_val;
            rh_in    = hi_val;
            rok_in   = start_ok && (hi_val > lo_val);
            state_in = mmn_pkg::ST_SIZE;
         end
         mmn_pkg::ST_SIZE: begin
            if (rok_ff && pend_v_ff) begin
               // Emit the pending region, keep the new one
               if (out_free) begin
                  out_v_in       = 1'b1;
                  out_in.base    = pend_b_ff;
                  out_in.size    = pend_s_ff;
                  out_in.valid   = 1'b1;
                  out_in.last    = 1'b0;
                  pend_b_in      = rl_ff;
                  pend_s_in      = rh_ff - rl_ff;
                  state_in       = final_ff ? mmn_pkg::ST_FINISH : mmn_pkg::ST_MERGE;
               end
            end else begin
               if (rok_ff) begin
                  pend_v_in = 1'b1;
                  pend_b_in = rl_ff;
                  pend_s_in = rh_ff - rl_ff;
               end
               state_in = final_ff ? mmn_pkg::ST_FINISH : mmn_pkg::ST_MERGE;
            end
         end
         mmn_pkg::ST_FINISH: begin
            if (out_free) begin
               out_v_in     = 1'b1;
               out_in.base  = pend_v_ff ? pend_b_ff : '0;
               out_in.size  = pend_v_ff ? pend_s_ff : '0;
               out_in.valid = pend_v_ff;
               out_in.last  = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = mmn_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mmn_pkg::ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mmn_pkg::ST_LOAD;
         remain_ff <= '0;
         have_ff   <= 1'b0;
         final_ff  <= 1'b0;
         rok_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
         have_ff   <= have_in;
         final_ff  <= final_in;
         rok_ff    <= rok_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cs_ff     <= cs_in;
      ce_ff     <= ce_in;
      cand_s_ff <= cand_s_in;
      cand_e_ff <= cand_e_in;
      rl_ff     <= rl_in;
      rh_ff     <= rh_in;
      pend_b_ff <= pend_b_in;
      pend_s_ff <= pend_s_in;
      out_ff    <= out_in;
   end

   assign busy      = (state_ff != mmn_pkg::ST_LOAD);
   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_ff;

endmodule
